// ===== hdl/nwsa_pkg.sv =====
package nwsa_pkg;

	// stream widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	// item kinds carried in s_axis_tuser
	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_INPUT  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 2'd1;

	// activation modes
	localparam logic [1:0] MODE_SIGMOID = 2'd0;
	localparam logic [1:0] MODE_TANH    = 2'd1;
	localparam logic [1:0] MODE_LINEAR  = 2'd2;

	// e^(-1/16) in Q32, step of the exponential recurrence
	localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;

	// sigmoid table: 257 entries in Q.24
	localparam int SIG_DEPTH = 257;
	localparam int SIG_W     = 24;

	// per-result data carried along the activation pipeline
	typedef struct packed {
		logic [31:0]        sum;
		logic               sat;
		logic               neg;
		logic               big;
		logic [19:0]        frac;
		logic signed [15:0] lin;
	} nwsa_side_t;

	// one result item
	typedef struct packed {
		logic signed [15:0] activation_result;
		logic [31:0]        weighted_sum;
		logic               sum_saturated;
	} nwsa_res_t;

endpackage

// ===== hdl/nwsa_act.sv =====
module nwsa_act
	import nwsa_pkg::*;
#(
	parameter int ACC_W = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  logic signed [ACC_W-1:0] in_sum,
	input  logic [1:0]              mode,
	output logic                    ready,
	output logic                    out_valid,
	output nwsa_res_t               out_res
);

	// table builder states
	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic signed [ACC_W-1:0] LIN_TOP  = ACC_W'(32'sd16777216);
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32'sd512);

	logic [1:0]  st_q;
	logic [8:0]  k_q;
	logic [32:0] e_q;
	logic [64:0] prod_q;
	logic [56:0] rem_q;
	logic [56:0] dsh_q;
	logic [23:0] quot_q;
	logic [4:0]  step_q;
	logic [33:0] den;

	logic [SIG_W-1:0] sig_mem [0:SIG_DEPTH-1];

	// front-end decode of the sum
	logic                    neg;
	logic [ACC_W-1:0]        mag;
	logic [ACC_W:0]          arg;
	logic [ACC_W-32:0]       upper;
	logic signed [ACC_W-1:0] lin_rnd;
	nwsa_side_t              side;
	logic [7:0]              idx;

	logic             vld_s4, vld_s5, vld_s6, vld_s7;
	nwsa_side_t       side_s4, side_s5, side_s6, side_s7;
	logic [SIG_W-1:0] lo_s4, hi_s4, lo_s5, diff_s5, lo_s6, ip_s6;
	logic [24:0]      sig_s7;

	logic [24:0]        sg_v;
	logic [15:0]        sg_r;
	logic [25:0]        th_m;
	logic [15:0]        th_r;
	logic signed [15:0] act;

	// table builder: e_k recurrence and restoring divide, one quotient bit a cycle
	assign den = 34'h1_0000_0000 + 34'(e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_LOAD;
			k_q    <= '0;
			e_q    <= 33'h1_0000_0000;
			step_q <= '0;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					step_q <= '0;
					st_q   <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd23) begin
						st_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					e_q <= 33'((prod_q + 65'd2147483648) >> 32);
					if (k_q == 9'(SIG_DEPTH - 1)) begin
						st_q <= ST_DONE;
					end else begin
						k_q  <= k_q + 9'd1;
						st_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					st_q <= ST_DONE;
				end
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD) begin
			rem_q  <= 57'h100_0000_0000_0000 + 57'(den >> 1);
			dsh_q  <= 57'(den) << 23;
			prod_q <= 65'(e_q) * 65'(EXP_STEP_Q32);
		end else if (st_q == ST_DIV) begin
			if (rem_q >= dsh_q) begin
				rem_q  <= rem_q - dsh_q;
				quot_q <= {quot_q[22:0], 1'b1};
			end else begin
				quot_q <= {quot_q[22:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign ready = (st_q == ST_DONE);

	// magnitude, saturation, linear result and table index
	always_comb begin
		neg     = in_sum[ACC_W-1];
		mag     = neg ? -in_sum : in_sum;
		arg     = (mode == MODE_TANH) ? {mag, 1'b0} : {1'b0, mag};
		upper   = in_sum[ACC_W-1:31];
		lin_rnd = (in_sum + HALF_LSB) >>> 10;
		idx     = arg[27:20];

		side.neg  = neg;
		side.sat  = !((&upper) || !(|upper));
		side.big  = |arg[ACC_W:28];
		side.frac = arg[19:0];
		if (side.sat) begin
			side.sum = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			side.sum = in_sum[31:0];
		end
		if (in_sum >= LIN_TOP) begin
			side.lin = 16'sd16384;
		end else if (in_sum <= -LIN_TOP) begin
			side.lin = -16'sd16384;
		end else begin
			side.lin = lin_rnd[15:0];
		end
	end

	// table write and the two-port registered read
	always_ff @(posedge clk) begin
		if (st_q == ST_WRITE) begin
			sig_mem[k_q] <= quot_q;
		end
		if (adv) begin
			lo_s4 <= sig_mem[9'(idx)];
			hi_s4 <= sig_mem[9'(idx) + 9'd1];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= in_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// interpolation: slope, product, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side;
			side_s5 <= side_s4;
			lo_s5   <= lo_s4;
			diff_s5 <= hi_s4 - lo_s4;
			side_s6 <= side_s5;
			lo_s6   <= lo_s5;
			ip_s6   <= 24'((44'(diff_s5) * 44'(side_s5.frac)) >> 20);
			side_s7 <= side_s6;
			sig_s7  <= side_s6.big ? 25'h100_0000 : 25'(lo_s6) + 25'(ip_s6);
		end
	end

	// final rounding per mode
	always_comb begin
		sg_v = side_s7.neg ? 25'h100_0000 - sig_s7 : sig_s7;
		sg_r = 16'((sg_v + 25'd512) >> 10);
		th_m = {sig_s7, 1'b0} - 26'h100_0000;
		th_r = 16'((th_m + 26'd512) >> 10);
		case (mode)
			MODE_SIGMOID: act = sg_r;
			MODE_TANH:    act = side_s7.neg ? -th_r : th_r;
			default:      act = side_s7.lin;
		endcase
		out_res.activation_result = act;
		out_res.weighted_sum      = side_s7.sum;
		out_res.sum_saturated     = side_s7.sat;
	end

	assign out_valid = vld_s7;

endmodule

// ===== hdl/neuron_weighted_sum_activation_unit.sv =====
// channel   | handshake                     | payload
// ----------+-------------------------------+-------------------------------------------
// cfg       | cfg_valid / cfg_ready         | cfg_index (0 mode, 1 count), cfg_data
// s_axis    | s_axis_tvalid / s_axis_tready | tdata: weight_index, value; tuser: operation
// m_axis    | m_axis_tvalid / m_axis_tready | tdata: weighted_sum, activation_result;
//           |                               | tuser: sum_saturated
//
// one item a cycle while s_axis_tready is high: weight read, multiply and accumulate each take
// one stage, the accumulator add is the only loop; a result then passes the activation stages
// and the output register; after reset a 257-entry sigmoid table is built, each entry by a load,
// a restoring divide and a write, with s_axis_tready low; cfg writes are taken at any time
// m_axis back-pressure fills an output register and a skid register, then holds the pipeline
module neuron_weighted_sum_activation_unit
	import nwsa_pkg::*;
#(
	parameter int MAX_INPUTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [6:0]             cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // weight_index[6:0], value[22:7], zero
	input  logic                   s_axis_tuser,  // operation
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // weighted_sum[31:0], activation_result[47:32]
	output logic                   m_axis_tuser   // sum_saturated
);

	localparam int ADDR_W = $clog2(MAX_INPUTS + 1);
	localparam int ACC_W  = 33 + ADDR_W;

	logic [1:0] mode_q;
	logic [6:0] cnt_q;

	logic [6:0]         in_widx;
	logic signed [15:0] in_value;
	logic               accept, wr_en, in_en, adv, act_ready;

	logic signed [15:0] wt_mem [0:MAX_INPUTS];
	logic signed [15:0] bias_q;

	logic [ADDR_W-1:0] pos_q, pos_nx, n_eff, rd_addr;
	logic              pos_last;

	logic                    vld_s1, first_s1, last_s1;
	logic signed [15:0]      value_s1, wt_s1, bias_s1;
	logic                    vld_s2, first_s2, last_s2;
	logic signed [31:0]      prod_s2;
	logic signed [ACC_W-1:0] base_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    res_s3;

	logic      act_vld, incoming, take;
	nwsa_res_t act_res, out_q, skid_q;
	logic      out_valid_q, skid_valid_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIGMOID;
			cnt_q  <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ACT_MODE:    mode_q <= cfg_data[1:0];
				REG_INPUT_COUNT: cnt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	assign in_widx       = s_axis_tdata[6:0];
	assign in_value      = s_axis_tdata[22:7];
	assign adv           = !skid_valid_q;
	assign s_axis_tready = act_ready && adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr_en         = accept && (s_axis_tuser == OP_WEIGHT) &&
	                       (32'(in_widx) <= 32'(MAX_INPUTS));
	assign in_en         = accept && (s_axis_tuser == OP_INPUT);

	// effective count and position
	always_comb begin
		if (cnt_q == 7'd0) begin
			n_eff = ADDR_W'(1);
		end else if (32'(cnt_q) > 32'(MAX_INPUTS)) begin
			n_eff = ADDR_W'(MAX_INPUTS);
		end else begin
			n_eff = ADDR_W'(cnt_q);
		end
		pos_nx   = pos_q + ADDR_W'(1);
		pos_last = (pos_nx >= n_eff);
		rd_addr  = pos_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_en) begin
			pos_q <= pos_last ? '0 : pos_nx;
		end
	end

	// weight store: write at accept, registered read for the next weight
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wt_mem[ADDR_W'(in_widx)] <= in_value;
		end
		if (wr_en && (in_widx == 7'd0)) begin
			bias_q <= in_value;
		end
		if (in_en) begin
			wt_s1    <= wt_mem[rd_addr];
			value_s1 <= in_value;
			bias_s1  <= bias_q;
			first_s1 <= (pos_q == '0);
			last_s1  <= pos_last;
		end
	end

	// pipeline valids and the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			res_s3 <= 1'b0;
			acc_q  <= '0;
		end else if (adv) begin
			vld_s1 <= in_en;
			vld_s2 <= vld_s1;
			res_s3 <= vld_s2 && last_s2;
			if (vld_s2) begin
				acc_q <= (first_s2 ? base_s2 : acc_q) + ACC_W'(prod_s2);
			end
		end
	end

	// multiply and bias term
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2  <= value_s1 * wt_s1;
			base_s2  <= -(ACC_W'(bias_s1) <<< 12);
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	nwsa_act #(
		.ACC_W(ACC_W)
	) u_act (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (res_s3),
		.in_sum    (acc_q),
		.mode      (mode_q),
		.ready     (act_ready),
		.out_valid (act_vld),
		.out_res   (act_res)
	);

	// output register with skid
	assign incoming = adv && act_vld;
	assign take     = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (incoming) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (incoming) begin
			if (out_valid_q && !take) begin
				skid_q <= act_res;
			end else begin
				out_q <= act_res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.activation_result, out_q.weighted_sum};
	assign m_axis_tuser  = out_q.sum_saturated;

endmodule

// ===== hdl/nwsa_checker.sv =====
module nwsa_checker
	import nwsa_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// a stalled item stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	// a clipped sum sits on one of the two limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000)
		else $error("saturated sum not at a limit");

	// activation of a clipped sum follows its sign
	a_sat_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && !m_axis_tdata[31] |-> !m_axis_tdata[47])
		else $error("negative activation for a large positive sum");

	a_sat_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && m_axis_tdata[31] |->
			m_axis_tdata[47] || m_axis_tdata[47:32] == 16'h0000)
		else $error("positive activation for a large negative sum");

endmodule

bind neuron_weighted_sum_activation_unit nwsa_checker u_nwsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
